// File: rtl/usb_transfer_descriptor_builder_unit_assert.svh
// Assertion macros used by the checker file.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef USB_TRANSFER_DESCRIPTOR_BUILDER_UNIT_ASSERT_SVH
`define USB_TRANSFER_DESCRIPTOR_BUILDER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define UTDB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in same-cycle check");

// Consequent must hold in the cycle after the antecedent
`define UTDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in next-cycle check");

`endif

// File: rtl/utdb_pkg.sv
// -----------------------------------------------------------------------------
// utdb_pkg
// Types, constants and the control store of the transfer descriptor builder.
// -----------------------------------------------------------------------------
package utdb_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DESC  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_OVF   = 2'd2;

  // Status word bits
  localparam logic [31:0] ST_ACTIVE = 32'h0080_0000;
  localparam logic [31:0] ST_RETRY3 = 32'h1800_0000;
  localparam logic [31:0] ST_IOC    = 32'h0100_0000;
  localparam logic [31:0] ST_LS     = 32'h0400_0000;

  // Packet identifiers
  localparam logic [7:0] PID_SETUP = 8'h2D;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_OUT   = 8'hE1;

  // Max length fields (length minus one)
  localparam logic [10:0] LEN_SETUP = 11'h007;
  localparam logic [10:0] LEN_NULL  = 11'h7FF;

  // Control store addressing
  localparam int UADDR_W = 4;

  localparam logic [UADDR_W-1:0] U_IDLE      = 4'd0;
  localparam logic [UADDR_W-1:0] U_CHK_EMPTY = 4'd1;
  localparam logic [UADDR_W-1:0] U_CHK_OVF   = 4'd2;
  localparam logic [UADDR_W-1:0] U_CHK_SETUP = 4'd3;
  localparam logic [UADDR_W-1:0] U_SETUP     = 4'd4;
  localparam logic [UADDR_W-1:0] U_DATA      = 4'd5;
  localparam logic [UADDR_W-1:0] U_CHK_TAIL  = 4'd6;
  localparam logic [UADDR_W-1:0] U_STATUS    = 4'd7;
  localparam logic [UADDR_W-1:0] U_EMPTY     = 4'd8;
  localparam logic [UADDR_W-1:0] U_OVF       = 4'd9;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SETUP,
    OP_DATA,
    OP_STATUS,
    OP_EMPTY,
    OP_OVF
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_EMPTY,
    C_OVF,
    C_NO_SETUP,
    C_NO_DATA,
    C_MORE_DATA
  } cond_t;

  typedef struct packed {
    op_t                op;
    cond_t              cond;
    logic [UADDR_W-1:0] target;
    logic               wait_req;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic out_free;
    logic empty;
    logic ovf;
    logic no_setup;
    logic no_data;
    logic more_data;
  } utdb_flags_t;

  // Microprogram: one control word per step
  function automatic ucode_t ucode_rom(input logic [UADDR_W-1:0] addr);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: U_IDLE, wait_req: 1'b0};
    unique case (addr)
      U_IDLE:      w = '{op: OP_NOP,    cond: C_NEVER,     target: U_IDLE,     wait_req: 1'b1};
      U_CHK_EMPTY: w = '{op: OP_NOP,    cond: C_EMPTY,     target: U_EMPTY,    wait_req: 1'b0};
      U_CHK_OVF:   w = '{op: OP_NOP,    cond: C_OVF,       target: U_OVF,      wait_req: 1'b0};
      U_CHK_SETUP: w = '{op: OP_NOP,    cond: C_NO_SETUP,  target: U_DATA,     wait_req: 1'b0};
      U_SETUP:     w = '{op: OP_SETUP,  cond: C_NO_DATA,   target: U_CHK_TAIL, wait_req: 1'b0};
      U_DATA:      w = '{op: OP_DATA,   cond: C_MORE_DATA, target: U_DATA,     wait_req: 1'b0};
      U_CHK_TAIL:  w = '{op: OP_NOP,    cond: C_NO_SETUP,  target: U_IDLE,     wait_req: 1'b0};
      U_STATUS:    w = '{op: OP_STATUS, cond: C_ALWAYS,    target: U_IDLE,     wait_req: 1'b0};
      U_EMPTY:     w = '{op: OP_EMPTY,  cond: C_ALWAYS,    target: U_IDLE,     wait_req: 1'b0};
      U_OVF:       w = '{op: OP_OVF,    cond: C_ALWAYS,    target: U_IDLE,     wait_req: 1'b0};
      default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    target: U_IDLE,     wait_req: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/utdb_if.sv
// -----------------------------------------------------------------------------
// utdb_req_if / utdb_res_if
// Valid/ready channels for transfer requests and descriptor results.
// -----------------------------------------------------------------------------
interface utdb_req_if;
  logic        valid;
  logic        ready;
  logic [6:0]  dev_addr;
  logic        low_speed;
  logic        has_setup;
  logic [31:0] setup_addr;
  logic        dir_in;
  logic [31:0] data_addr;
  logic [9:0]  length;
  logic        has_toggle;
  logic        toggle_in;

  modport source (
    output valid, dev_addr, low_speed, has_setup, setup_addr, dir_in,
           data_addr, length, has_toggle, toggle_in,
    input  ready
  );
  modport sink (
    input  valid, dev_addr, low_speed, has_setup, setup_addr, dir_in,
           data_addr, length, has_toggle, toggle_in,
    output ready
  );
endinterface

interface utdb_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] status_word;
  logic [31:0] token_word;
  logic [31:0] buffer_addr;
  logic        toggle_out;
  logic        last;

  modport source (
    output valid, kind, status_word, token_word, buffer_addr, toggle_out, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status_word, token_word, buffer_addr, toggle_out, last,
    output ready
  );
endinterface

// File: rtl/usb_transfer_descriptor_builder_unit.sv
// -----------------------------------------------------------------------------
// usb_transfer_descriptor_builder_unit
// Builds the transfer-descriptor words of one USB request, one per packet.
// -----------------------------------------------------------------------------
//  channel | dir | payload                                              | accept
//  req     | in  | dev_addr low_speed has_setup setup_addr dir_in       | valid & ready
//          |     | data_addr length has_toggle toggle_in                |
//  res     | out | kind status_word token_word buffer_addr toggle_out   | valid & ready
//          |     | last                                                 |
//
// A request runs an emitting step for each descriptor plus up to five control steps
// of the microprogram, which steps one control word per cycle unless a stalled
// result or the wait for a request holds it.
// Reset clears the step counter and the result valid flag.
// A stalled result holds the program on its emitting step; the next request
// is taken once the last result sits in the output register.
module usb_transfer_descriptor_builder_unit #(
  parameter int POOL_DEPTH = 64,
  parameter int PKT_BYTES  = 8
) (
  input logic        clk,
  input logic        rst,
  utdb_req_if.sink   req,
  utdb_res_if.source res
);
  import utdb_pkg::*;

  localparam int LIM_PLAIN = POOL_DEPTH * PKT_BYTES;
  localparam int LIM_CTL   = (POOL_DEPTH - 2) * PKT_BYTES;
  localparam int CMP_W     = ($clog2(LIM_PLAIN + 1) > 10) ? $clog2(LIM_PLAIN + 1) : 10;
  localparam int CHUNK_W   = $clog2(PKT_BYTES + 1);

  // Request registers
  logic [6:0]  dev_addr;
  logic        low_speed;
  logic        has_setup;
  logic [31:0] setup_addr;
  logic        dir_in;
  logic        has_toggle;
  logic        ovf;
  logic        tog;
  logic [9:0]  remain;
  logic [31:0] cur_addr;

  // Sequencer signals
  utdb_flags_t        flags;
  ucode_t             uc;
  logic               fire;
  logic               idle;
  logic               start;
  logic               req_ovf;
  logic               emit;

  // Datapath values
  logic [CHUNK_W-1:0] chunk;
  logic [10:0]        chunk_len;
  logic               data_tog;
  logic [31:0]        base_status;
  logic [7:0]         data_pid;
  logic [7:0]         hs_pid;

  // Result register
  logic        res_valid;
  logic [1:0]  kind;
  logic [31:0] status_word;
  logic [31:0] token_word;
  logic [31:0] buffer_addr;
  logic        toggle_out;
  logic        last;

  assign req.ready = idle;
  assign start     = req.valid && idle;

  // Overflow when the packets do not fit beside the control stages
  assign req_ovf = req.has_setup ? (CMP_W'(req.length) > CMP_W'(LIM_CTL))
                                 : (CMP_W'(req.length) > CMP_W'(LIM_PLAIN));

  assign flags.start     = start;
  assign flags.out_free  = !res_valid || res.ready;
  assign flags.empty     = !has_setup && (remain == 10'd0);
  assign flags.ovf       = ovf;
  assign flags.no_setup  = !has_setup;
  assign flags.no_data   = (remain == 10'd0);
  assign flags.more_data = (remain > 10'(PKT_BYTES));

  utdb_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uc    (uc),
    .fire  (fire),
    .idle  (idle)
  );

  // Size the current data packet
  assign chunk       = flags.more_data ? CHUNK_W'(PKT_BYTES) : remain[CHUNK_W-1:0];
  assign chunk_len   = 11'(chunk) - 11'd1;
  assign data_tog    = has_toggle ? tog : 1'b0;
  assign base_status = ST_ACTIVE | ST_RETRY3 | (low_speed ? ST_LS : 32'd0);
  assign data_pid    = dir_in ? PID_IN : PID_OUT;
  assign hs_pid      = dir_in ? PID_OUT : PID_IN;
  assign emit        = fire && (uc.op != OP_NOP);

  // Capture the request and step the data pointer and toggle
  always_ff @(posedge clk) begin
    if (start) begin
      dev_addr   <= req.dev_addr;
      low_speed  <= req.low_speed;
      has_setup  <= req.has_setup;
      setup_addr <= req.setup_addr;
      dir_in     <= req.dir_in;
      has_toggle <= req.has_toggle;
      ovf        <= req_ovf;
      tog        <= req.toggle_in;
      remain     <= req.length;
      cur_addr   <= req.data_addr;
    end else if (fire) begin
      case (uc.op)
        OP_SETUP: begin
          if (has_toggle) begin
            tog <= 1'b1;
          end
        end
        OP_DATA: begin
          remain   <= remain - 10'(chunk);
          cur_addr <= cur_addr + 32'(chunk);
          if (has_toggle) begin
            tog <= ~tog;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Load the result register; drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      case (uc.op)
        OP_SETUP: begin
          kind        <= KIND_DESC;
          status_word <= base_status;
          token_word  <= {LEN_SETUP, 1'b0, 1'b0, 4'd0, dev_addr, PID_SETUP};
          buffer_addr <= setup_addr;
          toggle_out  <= has_toggle ? 1'b1 : tog;
          last        <= 1'b0;
        end
        OP_DATA: begin
          kind        <= KIND_DESC;
          status_word <= base_status;
          token_word  <= {chunk_len, 1'b0, data_tog, 4'd0, dev_addr, data_pid};
          buffer_addr <= cur_addr;
          toggle_out  <= has_toggle ? ~tog : tog;
          last        <= !has_setup && !flags.more_data;
        end
        OP_STATUS: begin
          kind        <= KIND_DESC;
          status_word <= base_status | ST_IOC;
          token_word  <= {LEN_NULL, 1'b0, 1'b1, 4'd0, dev_addr, hs_pid};
          buffer_addr <= 32'd0;
          toggle_out  <= tog;
          last        <= 1'b1;
        end
        OP_EMPTY, OP_OVF: begin
          kind        <= (uc.op == OP_EMPTY) ? KIND_EMPTY : KIND_OVF;
          status_word <= 32'd0;
          token_word  <= 32'd0;
          buffer_addr <= 32'd0;
          toggle_out  <= tog;
          last        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.kind        = kind;
  assign res.status_word = status_word;
  assign res.token_word  = token_word;
  assign res.buffer_addr = buffer_addr;
  assign res.toggle_out  = toggle_out;
  assign res.last        = last;

endmodule

// File: rtl/utdb_seq.sv
// -----------------------------------------------------------------------------
// utdb_seq
// Step counter, control store and jump logic of the descriptor builder.
// -----------------------------------------------------------------------------
module utdb_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  utdb_pkg::utdb_flags_t flags,
  output utdb_pkg::ucode_t     uc,
  output logic                 fire,
  output logic                 idle
);
  import utdb_pkg::*;

  logic [UADDR_W-1:0] step;
  logic [UADDR_W-1:0] step_next;
  logic               taken;

  // Fetch the current control word
  assign uc   = ucode_rom(step);
  assign idle = (step == U_IDLE);

  // Select the jump condition
  always_comb begin
    case (uc.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_EMPTY:     taken = flags.empty;
      C_OVF:       taken = flags.ovf;
      C_NO_SETUP:  taken = flags.no_setup;
      C_NO_DATA:   taken = flags.no_data;
      C_MORE_DATA: taken = flags.more_data;
      default:     taken = 1'b0;
    endcase
  end

  // Hold on a missing request or a full output register
  always_comb begin
    if (uc.wait_req) begin
      fire = flags.start;
    end else if (uc.op != OP_NOP) begin
      fire = flags.out_free;
    end else begin
      fire = 1'b1;
    end
  end

  assign step_next = taken ? uc.target : step + 1'b1;

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= U_IDLE;
    end else if (fire) begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/utdb_checker.sv
// -----------------------------------------------------------------------------
// utdb_checker
// Port-level checks of the descriptor builder, bound to the top level.
// -----------------------------------------------------------------------------
`include "usb_transfer_descriptor_builder_unit_assert.svh"

module utdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [31:0] status_word,
  input logic [31:0] token_word,
  input logic        last
);
  import utdb_pkg::*;

  // A waiting result stays valid and holds its token word and last flag
  `UTDB_ASSERT_NEXT(a_res_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(token_word) && $stable(last))

  // A new request is not taken straight after one was accepted
  `UTDB_ASSERT_NEXT(a_one_req, clk, rst, in_valid && in_ready, !in_ready)

  // Empty and overflow results close the request and carry zero status and token words
  `UTDB_ASSERT_SAME(a_flag_res, clk, rst, out_valid && (kind != KIND_DESC), last && (status_word == 32'd0) && (token_word == 32'd0))

  // Every descriptor is marked active
  `UTDB_ASSERT_SAME(a_active, clk, rst, out_valid && (kind == KIND_DESC), status_word[23])

endmodule

bind usb_transfer_descriptor_builder_unit utdb_checker u_utdb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .kind        (res.kind),
  .status_word (res.status_word),
  .token_word  (res.token_word),
  .last        (res.last)
);

// File: sim/tb.sv
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the USB transfer descriptor builder. A short table
// of directed requests covers empty and overflow requests, the exact pool
// fit, setup and status stages, toggle handling and buffer address wrap. A
// few rows carry their descriptor words typed in. A random mix of requests
// follows. Every result that comes out is compared with the typed words or a
// software prediction of the descriptor list, while both channels idle in
// random bursts.
// -----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utdb_pkg::*;

  localparam int POOL_DEPTH     = 64;
  localparam int PKT_BYTES      = 8;
  localparam int N_RANDOM       = 402;
  localparam int CALM_TAIL      = 60;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_DIRECTED     = 18;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic        low_speed;
    logic        has_setup;
    logic [31:0] setup_addr;
    logic        dir_in;
    logic [31:0] data_addr;
    logic [9:0]  length;
    logic        has_toggle;
    logic        toggle_in;
  } xfer_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] status_word;
    logic [31:0] token_word;
    logic [31:0] buffer_addr;
    logic        toggle_out;
    logic        last;
  } td_word_t;

  // A request plus, for the simplest rows, the single descriptor it yields
  typedef struct {
    xfer_req_t req;
    bit        fixed;
    td_word_t  td;
  } req_row_t;

  logic clk;
  logic rst;

  utdb_req_if req_ch ();
  utdb_res_if res_ch ();

  usb_transfer_descriptor_builder_unit #(
    .POOL_DEPTH(POOL_DEPTH),
    .PKT_BYTES(PKT_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Directed requests: dev_addr, low_speed, has_setup, setup_addr, dir_in,
  // data_addr, length, has_toggle, toggle_in; then the typed descriptor
  req_row_t directed_table [0:N_DIRECTED-1] = '{
    // nothing to send, both toggle values
    '{'{7'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 10'd0, 1'b0, 1'b0},
      1'b1, '{KIND_EMPTY, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
    '{'{7'd127, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 10'd0, 1'b1, 1'b1},
      1'b1, '{KIND_EMPTY, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1}},
    // pool overflow: longest request, and one past the pool with and without setup
    '{'{7'd5, 1'b0, 1'b0, 32'h0000_1000, 1'b1, 32'h0000_2000, 10'd1023, 1'b1, 1'b0},
      1'b1, '{KIND_OVF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
    '{'{7'd9, 1'b1, 1'b1, 32'h0000_3000, 1'b0, 32'h0000_4000, 10'd497, 1'b0, 1'b1},
      1'b1, '{KIND_OVF, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1}},
    '{'{7'd64, 1'b0, 1'b0, 32'h0000_5000, 1'b0, 32'h0000_6000, 10'd513, 1'b1, 1'b0},
      1'b1, '{KIND_OVF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1}},
    '{'{7'd127, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b1},
      1'b1, '{KIND_OVF, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1}},
    // single one-byte packet, all fields low and all fields high
    '{'{7'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 10'd1, 1'b0, 1'b0},
      1'b1, '{KIND_DESC, 32'h1880_0000, 32'h0000_00E1, 32'h0000_0000, 1'b0, 1'b1}},
    '{'{7'd127, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 10'd1, 1'b1, 1'b1},
      1'b1, '{KIND_DESC, 32'h1C80_0000, 32'h0008_7F69, 32'hFFFF_FFFF, 1'b0, 1'b1}},
    // exact pool fit without and with setup
    '{'{7'd33, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'h1000_0000, 10'd512, 1'b1, 1'b0},
      1'b0, '0},
    '{'{7'd66, 1'b1, 1'b1, 32'h2000_0008, 1'b1, 32'h2000_0100, 10'd496, 1'b1, 1'b1},
      1'b0, '0},
    // setup and status only
    '{'{7'd1, 1'b0, 1'b1, 32'h0000_0040, 1'b0, 32'h0000_0080, 10'd0, 1'b1, 1'b0},
      1'b0, '0},
    '{'{7'd2, 1'b1, 1'b1, 32'h0000_00C0, 1'b1, 32'h0000_0100, 10'd0, 1'b0, 1'b1},
      1'b0, '0},
    // control transfers with short and full packets
    '{'{7'd85, 1'b1, 1'b1, 32'hA5A5_A5A0, 1'b1, 32'h5A5A_5A50, 10'd9, 1'b1, 1'b0},
      1'b0, '0},
    '{'{7'd42, 1'b0, 1'b1, 32'h0000_1230, 1'b0, 32'h0000_4560, 10'd8, 1'b0, 1'b1},
      1'b0, '0},
    // data buffer address wraps past the top of the address space
    '{'{7'd17, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'hFFFF_FFFC, 10'd20, 1'b1, 1'b1},
      1'b0, '0},
    // toggle tracking off across several packets, then two short requests
    '{'{7'd100, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 32'h8000_0000, 10'd64, 1'b0, 1'b1},
      1'b0, '0},
    '{'{7'd127, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0010, 10'd1, 1'b0, 1'b0},
      1'b0, '0},
    '{'{7'd3, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0777, 10'd7, 1'b1, 1'b0},
      1'b0, '0}
  };

  req_row_t  req_backlog [$];
  td_word_t  pending_tds [$];
  req_row_t  in_flight;

  int send_gap;
  int stall_left;
  int idle_cycles;
  int n_requests;
  int n_results;
  int n_desc;
  int n_empty;
  int n_ovf;
  int n_mismatch;
  int n_leftover;

  function automatic logic [31:0] pack_token(input logic [10:0] maxlen, input logic tog,
                                             input logic [6:0] addr, input logic [7:0] pid);
    return {maxlen, 1'b0, tog, 4'b0000, addr, pid};
  endfunction

  // Work out the descriptor list of one request and queue it
  function automatic void build_descriptors(input xfer_req_t r);
    int          packets;
    int          total;
    int          offset;
    int          chunk;
    int          k;
    logic        tog;
    logic        dt;
    logic [31:0] base;
    logic [7:0]  pid;
    logic [7:0]  hs_pid;
    packets = (int'(r.length) + PKT_BYTES - 1) / PKT_BYTES;
    total   = packets + (r.has_setup ? 2 : 0);
    tog     = r.toggle_in;
    if (total == 0) begin
      pending_tds.push_back('{KIND_EMPTY, 32'h0, 32'h0, 32'h0, tog, 1'b1});
      return;
    end
    if (total > POOL_DEPTH) begin
      pending_tds.push_back('{KIND_OVF, 32'h0, 32'h0, 32'h0, tog, 1'b1});
      return;
    end
    base   = ST_ACTIVE | ST_RETRY3 | (r.low_speed ? ST_LS : 32'h0);
    pid    = r.dir_in ? PID_IN : PID_OUT;
    hs_pid = r.dir_in ? PID_OUT : PID_IN;
    k      = 0;
    offset = 0;
    // setup stage always goes out with toggle 0
    if (r.has_setup) begin
      if (r.has_toggle) tog = 1'b1;
      pending_tds.push_back('{KIND_DESC, base,
                              pack_token(LEN_SETUP, 1'b0, r.dev_addr, PID_SETUP),
                              r.setup_addr, tog, logic'(k + 1 == total)});
      k++;
    end
    // data packets, flipping the toggle after each when tracked
    for (int p = 0; p < packets; p++) begin
      chunk = int'(r.length) - offset;
      if (chunk > PKT_BYTES) chunk = PKT_BYTES;
      dt = r.has_toggle ? tog : 1'b0;
      if (r.has_toggle) tog = ~tog;
      pending_tds.push_back('{KIND_DESC, base,
                              pack_token(11'(chunk - 1), dt, r.dev_addr, pid),
                              r.data_addr + 32'(offset), tog, logic'(k + 1 == total)});
      offset += chunk;
      k++;
    end
    // zero-length status stage in the opposite direction
    if (r.has_setup) begin
      pending_tds.push_back('{KIND_DESC, base | ST_IOC,
                              pack_token(LEN_NULL, 1'b1, r.dev_addr, hs_pid),
                              32'h0, tog, 1'b1});
    end
  endfunction

  // Mostly short transfers, some long ones and a few anywhere in range
  function automatic xfer_req_t random_request();
    xfer_req_t r;
    int        pick;
    r.dev_addr   = 7'($urandom_range(0, 127));
    r.low_speed  = 1'($urandom_range(0, 1));
    r.has_setup  = 1'($urandom_range(0, 1));
    r.setup_addr = $urandom;
    r.dir_in     = 1'($urandom_range(0, 1));
    r.data_addr  = $urandom;
    r.has_toggle = 1'($urandom_range(0, 1));
    r.toggle_in  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    if (pick == 0)
      r.length = 10'd0;
    else if (pick < 14)
      r.length = 10'($urandom_range(0, 64));
    else if (pick < 18)
      r.length = 10'($urandom_range(65, 520));
    else
      r.length = 10'($urandom_range(0, 1023));
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request side: predict on each transfer, then present the next request
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (in_flight.fixed)
          pending_tds.push_back(in_flight.td);
        else
          build_descriptors(in_flight.req);
        n_requests++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_flight = req_backlog.pop_front();
          req_ch.dev_addr   <= in_flight.req.dev_addr;
          req_ch.low_speed  <= in_flight.req.low_speed;
          req_ch.has_setup  <= in_flight.req.has_setup;
          req_ch.setup_addr <= in_flight.req.setup_addr;
          req_ch.dir_in     <= in_flight.req.dir_in;
          req_ch.data_addr  <= in_flight.req.data_addr;
          req_ch.length     <= in_flight.req.length;
          req_ch.has_toggle <= in_flight.req.has_toggle;
          req_ch.toggle_in  <= in_flight.req.toggle_in;
          req_ch.valid      <= 1'b1;
          if (req_backlog.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 19);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: stall in bursts until the tail of the run
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (req_backlog.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 19);
    end
  end

  // Compare each result transfer with the oldest predicted descriptor
  always @(posedge clk) begin : check_results
    td_word_t got;
    td_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.kind, res_ch.status_word, res_ch.token_word, res_ch.buffer_addr,
              res_ch.toggle_out, res_ch.last};
      n_results++;
      case (got.kind)
        KIND_DESC:  n_desc++;
        KIND_EMPTY: n_empty++;
        KIND_OVF:   n_ovf++;
        default:    ;
      endcase
      if (pending_tds.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result %0d with nothing expected: kind %0d token %h", $realtime,
                   n_results, got.kind, got.token_word);
      end else begin
        want = pending_tds.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: result %0d mismatch", $realtime, n_results);
            $display("  expected kind %0d status %h token %h buf %h toggle %b last %b",
                     want.kind, want.status_word, want.token_word, want.buffer_addr,
                     want.toggle_out, want.last);
            $display("  actual   kind %0d status %h token %h buf %h toggle %b last %b",
                     got.kind, got.status_word, got.token_word, got.buffer_addr,
                     got.toggle_out, got.last);
          end
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d descriptors outstanding",
                 idle_cycles, pending_tds.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  // Sequence the run
  initial begin
    req_row_t row;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.dev_addr   = '0;
    req_ch.low_speed  = 1'b0;
    req_ch.has_setup  = 1'b0;
    req_ch.setup_addr = '0;
    req_ch.dir_in     = 1'b0;
    req_ch.data_addr  = '0;
    req_ch.length     = '0;
    req_ch.has_toggle = 1'b0;
    req_ch.toggle_in  = 1'b0;
    res_ch.ready      = 1'b0;
    foreach (directed_table[i]) req_backlog.push_back(directed_table[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      row.req   = random_request();
      row.fixed = 1'b0;
      row.td    = '0;
      req_backlog.push_back(row);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // hold until every request is in, then until every descriptor is out
    while (req_backlog.size() != 0 || req_ch.valid) @(posedge clk);
    while (pending_tds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_leftover = pending_tds.size();

    $display("%0d requests (%0d from the directed table) gave %0d results:", n_requests,
             N_DIRECTED, n_results);
    $display("  %0d descriptors, %0d empty, %0d overflow; %0d mismatches, %0d left over",
             n_desc, n_empty, n_ovf, n_mismatch, n_leftover);
    if (n_mismatch == 0 && n_leftover == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
